// File: src/mmas_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the multichannel moving average scaler.
package mmas_pkg;

    localparam int NUM_CHANNELS     = 8;
    localparam int CH_W             = 3;
    localparam int CODE_W           = 12;
    localparam int TOTAL_W          = 16;
    localparam int SCALE_W          = 16;
    localparam int CMD_W            = 8;
    localparam int MAX_AVG_BITS     = 4;
    localparam int AVG_BITS_DEFAULT = 4;
    localparam int MID_DEPTH        = 4;
    localparam int OUT_DEPTH        = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;

    // Scaling: q = (x * span) / 4095, done as a reciprocal multiply.
    // RECIP = ceil(2^40 / 4095) is exact for every product up to 4095 * 65535.
    localparam int PROD_W      = CODE_W + SCALE_W;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 40;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd4095 + 64'd1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SCALE    = 2'd0,
        CFG_MAX_SCALE    = 2'd1,
        CFG_SINGLE_ENDED = 2'd2,
        CFG_POWER_MODE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SCALE_W-1:0] min_scale;
        logic [SCALE_W-1:0] max_scale;
        logic               single_ended;
        logic [1:0]         power_mode;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [CODE_W-1:0] sample_code;
        logic              transfer_ok;
    } t_in;

    typedef struct packed {
        logic               accepted;
        logic [CMD_W-1:0]   command_byte;
        logic [SCALE_W-1:0] latest_scaled;
        logic [SCALE_W-1:0] average_scaled;
        logic [TOTAL_W-1:0] running_total;
    } t_out;

    // Classified transaction handed from the front to the back.
    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic [CODE_W-1:0]       sample_code;
        logic                    transfer_ok;
        logic [MAX_AVG_BITS-1:0] slot;
        logic [CMD_W-1:0]        command_byte;
    } t_work;

endpackage

// File: src/multichannel_moving_average_scaler.sv
`timescale 1ns / 1ps
// Top level: configuration registers, front end, work queue, back end, result queue.
//
//  channel   direction  handshake          payload
//  input     in         push / full        i_item   (channel, sample_code, transfer_ok)
//  result    out        empty / pop        o_result (accepted .. running_total)
//  config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One transaction per cycle sustained while the result queue has room; a result passes
// through the work queue, window memory read, scale multiply and reciprocal multiply.
// Reset is synchronous and clears slots, totals and window valid bits.
// With pop low the result queue fills, the back end stops issuing when queue plus
// in-flight transactions reach its depth, and full rises once the work queue fills.
module multichannel_moving_average_scaler #(
    parameter int AVG_BITS = mmas_pkg::AVG_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  mmas_pkg::t_in                       i_item,
    output logic                                empty,
    input  logic                                pop,
    output mmas_pkg::t_out                      o_result,
    input  logic                                i_cfg_we,
    input  logic [mmas_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mmas_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mmas_pkg::*;

    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    t_cfg              r_cfg;
    logic              front_wr;
    t_work             front_work;
    t_work             q_work;
    logic              q_empty;
    logic              q_pop;
    logic              res_valid;
    t_out              res;
    logic              out_full;
    logic [OCNT_W-1:0] out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_scale    <= SCALE_W'(0);
            r_cfg.max_scale    <= SCALE_W'(4095);
            r_cfg.single_ended <= 1'b1;
            r_cfg.power_mode   <= 2'b11;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_SCALE:    r_cfg.min_scale    <= i_cfg_data;
                CFG_MAX_SCALE:    r_cfg.max_scale    <= i_cfg_data;
                CFG_SINGLE_ENDED: r_cfg.single_ended <= i_cfg_data[0];
                CFG_POWER_MODE:   r_cfg.power_mode   <= i_cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    mmas_front #(
        .AVG_BITS (AVG_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_q_full (full),
        .o_wr     (front_wr),
        .o_work   (front_work)
    );

    mmas_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (MID_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_wdata (front_work),
        .i_rd    (q_pop),
        .o_rdata (q_work),
        .o_full  (full),
        .o_empty (q_empty),
        .o_count ()
    );

    mmas_back #(
        .AVG_BITS  (AVG_BITS),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_work      (q_work),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_cfg       (r_cfg),
        .i_out_count (out_count),
        .o_res_valid (res_valid),
        .o_result    (res)
    );

    mmas_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_wdata (res),
        .i_rd    (pop),
        .o_rdata (o_result),
        .o_full  (out_full),
        .o_empty (empty),
        .o_count (out_count)
    );

    // credit check in the back end keeps the result queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !out_full)
        else $error("result dropped at full result queue");
endmodule

// File: src/mmas_fifo.sv
`timescale 1ns / 1ps
// Small register-based FIFO used between the front and back and for results.
module mmas_fifo #(
    parameter int WIDTH = $bits(mmas_pkg::t_work),
    parameter int DEPTH = mmas_pkg::MID_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_rd,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_ok;
    logic             rd_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rd_ptr];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({wr_ok, rd_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

// File: src/mmas_front.sv
`timescale 1ns / 1ps
// Front end: accepts samples, advances the channel write slot, builds the command byte.
module mmas_front #(
    parameter int AVG_BITS = mmas_pkg::AVG_BITS_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mmas_pkg::t_in   i_item,
    input  mmas_pkg::t_cfg  i_cfg,
    input  logic            i_q_full,
    output logic            o_wr,
    output mmas_pkg::t_work o_work
);
    import mmas_pkg::*;

    logic [AVG_BITS-1:0] r_slot [NUM_CHANNELS];
    logic [AVG_BITS-1:0] cur_slot;
    logic [AVG_BITS-1:0] n_slot;
    logic                accept;

    assign accept   = i_push && !i_q_full;
    assign cur_slot = r_slot[i_item.channel];
    // slot wraps at the window length by width alone
    assign n_slot   = cur_slot + 1'b1;

    always_comb begin
        o_wr                = accept;
        o_work.channel      = i_item.channel;
        o_work.sample_code  = i_item.sample_code;
        o_work.transfer_ok  = i_item.transfer_ok;
        // good transfer reads the slot it overwrites, a failed one the latest sample
        o_work.slot         = MAX_AVG_BITS'(i_item.transfer_ok ? n_slot : cur_slot);
        o_work.command_byte = {i_cfg.single_ended, i_item.channel[0], i_item.channel[2],
                               i_item.channel[1], i_cfg.power_mode, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_slot[i] <= '0;
            end
        end else if (accept && i_item.transfer_ok) begin
            r_slot[i_item.channel] <= n_slot;
        end
    end
endmodule

// File: src/mmas_back.sv
`timescale 1ns / 1ps
// Back end: sample window read-modify-write, running totals and output scaling.
module mmas_back #(
    parameter int AVG_BITS  = mmas_pkg::AVG_BITS_DEFAULT,
    parameter int OUT_DEPTH = mmas_pkg::OUT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mmas_pkg::t_work                i_work,
    input  logic                           i_q_empty,
    output logic                           o_q_pop,
    input  mmas_pkg::t_cfg                 i_cfg,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_res_valid,
    output mmas_pkg::t_out                 o_result
);
    import mmas_pkg::*;

    localparam int ADDR_W  = CH_W + AVG_BITS;
    localparam int MEM_D   = NUM_CHANNELS << AVG_BITS;
    localparam int OCNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int MUL_W   = PROD_W + RECIP_W;

    // sample window memory and its per-entry valid bits
    logic [CODE_W-1:0]  r_mem [MEM_D];
    logic [MEM_D-1:0]   r_valid;
    logic [TOTAL_W-1:0] r_total [NUM_CHANNELS];

    logic [ADDR_W-1:0]  rd_addr;
    logic               w_en;

    // stage 1: memory data
    logic               r_s1_valid;
    t_work              r_s1_work;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic               r_s1_hit;
    logic [CODE_W-1:0]  r_s1_fwd;
    logic               r_s1_vbit;
    logic [CODE_W-1:0]  r_s1_q;

    // stage 2: values to scale
    logic               r_s2_valid;
    logic               r_s2_acc;
    logic [CMD_W-1:0]   r_s2_cmd;
    logic [TOTAL_W-1:0] r_s2_total;
    logic [CODE_W-1:0]  r_s2_lat;
    logic [CODE_W-1:0]  r_s2_avg;

    // stage 3: products
    logic               r_s3_valid;
    logic               r_s3_acc;
    logic [CMD_W-1:0]   r_s3_cmd;
    logic [TOTAL_W-1:0] r_s3_total;
    logic [PROD_W-1:0]  r_s3_p_lat;
    logic [PROD_W-1:0]  r_s3_p_avg;

    logic [CODE_W-1:0]  stored;
    logic [TOTAL_W-1:0] cur_total;
    logic [TOTAL_W-1:0] n_total;
    logic [TOTAL_W-1:0] total_out;
    logic [CODE_W-1:0]  lat_raw;
    logic               scale_down;
    logic [SCALE_W-1:0] span;
    logic [MUL_W-1:0]   m_lat;
    logic [MUL_W-1:0]   m_avg;
    logic [SCALE_W-1:0] q_lat;
    logic [SCALE_W-1:0] q_avg;
    logic [1:0]         inflight;
    logic               credit_ok;

    // issue only when the result queue can hold everything in flight
    assign inflight  = 2'(r_s1_valid) + 2'(r_s2_valid) + 2'(r_s3_valid);
    assign credit_ok = ((OCNT_W+1)'(i_out_count) + (OCNT_W+1)'(inflight))
                       < (OCNT_W+1)'(OUT_DEPTH);
    assign o_q_pop   = !i_q_empty && credit_ok;
    assign rd_addr   = {i_work.channel, i_work.slot[AVG_BITS-1:0]};
    assign w_en      = r_s1_valid && r_s1_work.transfer_ok;

    always_comb begin
        // a write on the same edge as the read is forwarded
        if (r_s1_hit) begin
            stored = r_s1_fwd;
        end else if (r_s1_vbit) begin
            stored = r_s1_q;
        end else begin
            stored = '0;
        end
        cur_total = r_total[r_s1_work.channel];
        n_total   = cur_total - TOTAL_W'(stored) + TOTAL_W'(r_s1_work.sample_code);
        total_out = r_s1_work.transfer_ok ? n_total : cur_total;
        lat_raw   = r_s1_work.transfer_ok ? r_s1_work.sample_code : stored;
    end

    always_comb begin
        scale_down = i_cfg.max_scale < i_cfg.min_scale;
        span       = scale_down ? (i_cfg.min_scale - i_cfg.max_scale)
                                : (i_cfg.max_scale - i_cfg.min_scale);
        m_lat      = MUL_W'(r_s3_p_lat) * MUL_W'(RECIP);
        m_avg      = MUL_W'(r_s3_p_avg) * MUL_W'(RECIP);
        q_lat      = m_lat[RECIP_SHIFT +: SCALE_W];
        q_avg      = m_avg[RECIP_SHIFT +: SCALE_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[r_s1_addr] <= r_s1_work.sample_code;
        end
        if (o_q_pop) begin
            r_s1_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_work <= i_work;
            r_s1_addr <= rd_addr;
            r_s1_vbit <= r_valid[rd_addr];
            r_s1_fwd  <= r_s1_work.sample_code;
        end
        r_s2_acc   <= r_s1_work.transfer_ok;
        r_s2_cmd   <= r_s1_work.command_byte;
        r_s2_total <= total_out;
        r_s2_lat   <= lat_raw;
        r_s2_avg   <= CODE_W'(total_out >> AVG_BITS);
        r_s3_acc   <= r_s2_acc;
        r_s3_cmd   <= r_s2_cmd;
        r_s3_total <= r_s2_total;
        r_s3_p_lat <= PROD_W'(r_s2_lat) * PROD_W'(span);
        r_s3_p_avg <= PROD_W'(r_s2_avg) * PROD_W'(span);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s1_hit   <= 1'b0;
            r_valid    <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_total[i] <= '0;
            end
        end else begin
            r_s1_valid <= o_q_pop;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (o_q_pop) begin
                r_s1_hit <= w_en && (r_s1_addr == rd_addr);
            end
            if (w_en) begin
                r_valid[r_s1_addr]          <= 1'b1;
                r_total[r_s1_work.channel]  <= n_total;
            end
        end
    end

    always_comb begin
        o_res_valid             = r_s3_valid;
        o_result.accepted       = r_s3_acc;
        o_result.command_byte   = r_s3_cmd;
        o_result.latest_scaled  = scale_down ? i_cfg.min_scale - q_lat
                                             : i_cfg.min_scale + q_lat;
        o_result.average_scaled = scale_down ? i_cfg.min_scale - q_avg
                                             : i_cfg.min_scale + q_avg;
        o_result.running_total  = r_s3_total;
    end

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(i_out_count) + int'(inflight)) <= OUT_DEPTH)
        else $error("result queue overcommitted");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |=> r_s2_valid)
        else $error("transaction lost between stage 1 and stage 2");

    a_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> r_valid[$past(r_s1_addr)])
        else $error("written window entry not marked valid");

    a_hit_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && !w_en) |=> !r_s1_hit)
        else $error("forwarding without a write");
endmodule

// File: dv/window_result_checker.sv
`timescale 1ns / 1ps
// Checker for the moving average scaler: predicts each result and compares it.
module window_result_checker #(
    parameter int AVG_BITS = mmas_pkg::AVG_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic                            i_full,
    input  mmas_pkg::t_in                   i_item,
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  mmas_pkg::t_out                  i_result,
    input  logic                            i_cfg_we,
    input  logic [mmas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mmas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);
    import mmas_pkg::*;

    localparam int SLOTS = 1 << MAX_AVG_BITS;
    localparam int CODE_FULL = 4095;

    logic [CODE_W-1:0]       win_mem [NUM_CHANNELS][SLOTS];
    logic [MAX_AVG_BITS-1:0] slot_ptr [NUM_CHANNELS];
    logic [TOTAL_W-1:0]      sum_acc [NUM_CHANNELS];

    logic [SCALE_W-1:0] cfg_min;
    logic [SCALE_W-1:0] cfg_max;
    logic               cfg_single;
    logic [1:0]         cfg_power;

    t_out expected_results[$];
    int   mismatches = 0;

    assign o_errors  = mismatches;
    assign o_pending = expected_results.size();

    function automatic logic [SCALE_W-1:0] map_code(input int unsigned x);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned v;
        lo = cfg_min;
        hi = cfg_max;
        v  = x & CODE_FULL;
        // truncate toward zero on either slope
        if (hi >= lo) begin
            return SCALE_W'(lo + (v * (hi - lo)) / CODE_FULL);
        end else begin
            return SCALE_W'(lo - (v * (lo - hi)) / CODE_FULL);
        end
    endfunction

    function automatic t_out next_window_result(input t_in it);
        t_out               r;
        int unsigned        nslot;
        logic [CH_W-1:0]    ch;
        ch = it.channel;
        if (it.transfer_ok) begin
            nslot = (int'(slot_ptr[ch]) + 1) & ((1 << AVG_BITS) - 1);
            slot_ptr[ch] = MAX_AVG_BITS'(nslot);
            sum_acc[ch] = sum_acc[ch] - TOTAL_W'(win_mem[ch][nslot]) + TOTAL_W'(it.sample_code);
            win_mem[ch][nslot] = it.sample_code;
        end
        r.accepted       = it.transfer_ok;
        r.command_byte   = {cfg_single, ch[0], ch[2], ch[1], cfg_power, 2'b00};
        r.latest_scaled  = map_code(win_mem[ch][slot_ptr[ch]]);
        r.average_scaled = map_code(sum_acc[ch] >> AVG_BITS);
        r.running_total  = sum_acc[ch];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                for (int s = 0; s < SLOTS; s++) win_mem[c][s] = '0;
                slot_ptr[c] = '0;
                sum_acc[c]  = '0;
            end
            cfg_min    = 16'd0;
            cfg_max    = 16'd4095;
            cfg_single = 1'b1;
            cfg_power  = 2'd3;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_SCALE:    cfg_min    = i_cfg_data;
                    CFG_MAX_SCALE:    cfg_max    = i_cfg_data;
                    CFG_SINGLE_ENDED: cfg_single = i_cfg_data[0];
                    CFG_POWER_MODE:   cfg_power  = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                expected_results.push_back(next_window_result(i_item));
            end
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", 16'(want.accepted), 16'(i_result.accepted));
                    check_field("command_byte", 16'(want.command_byte),
                                16'(i_result.command_byte));
                    check_field("latest_scaled", want.latest_scaled, i_result.latest_scaled);
                    check_field("average_scaled", want.average_scaled,
                                i_result.average_scaled);
                    check_field("running_total", want.running_total, i_result.running_total);
                end
            end
        end
    end

endmodule

// File: dv/multichannel_moving_average_scaler_test.sv
`timescale 1ns / 1ps
// Testbench top: stimulus, handshake idling, config phases and the verdict.
module multichannel_moving_average_scaler_test;
    import mmas_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 300;
    localparam int PHASE_ITEMS = 180;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_in                   i_item;
    logic                  empty;
    logic                  pop;
    t_out                  o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int chk_errors;
    int chk_pending;
    int sent = 0;
    int received = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    bit long_hold_req = 1'b0;

    always #10 i_clk = ~i_clk;

    multichannel_moving_average_scaler #(
        .AVG_BITS(AVG_BITS_DEFAULT)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    window_result_checker #(
        .AVG_BITS(AVG_BITS_DEFAULT)
    ) result_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_item    (i_item),
        .i_empty   (empty),
        .i_pop     (pop),
        .i_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    function automatic t_in make_item(input int ch, input int code, input bit ok);
        t_in it;
        it.channel     = CH_W'(ch);
        it.sample_code = CODE_W'(code);
        it.transfer_ok = ok;
        return it;
    endfunction

    // Offer one input transaction after a gap; return at the edge that takes it.
    task automatic send_item(input t_in it, input int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full !== 1'b0);
        sent++;
    endtask

    // Hold off input until every expected result has been popped.
    task automatic drain();
        push <= 1'b0;
        while (received < sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_scaling(input int lo, input int hi, input bit se, input int pm);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_MIN_SCALE; i_cfg_data <= CFG_DATA_W'(lo);
        @(posedge i_clk);
        i_cfg_idx <= CFG_MAX_SCALE; i_cfg_data <= CFG_DATA_W'(hi);
        @(posedge i_clk);
        i_cfg_idx <= CFG_SINGLE_ENDED; i_cfg_data <= CFG_DATA_W'(se);
        @(posedge i_clk);
        i_cfg_idx <= CFG_POWER_MODE; i_cfg_data <= CFG_DATA_W'(pm);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int n);
        int       fast_left;
        int       burst_left;
        int       burst_ch;
        int       burst_code;
        int       code;
        int       pick;
        t_in      it;
        fast_left  = 0;
        burst_left = 0;
        burst_ch   = 0;
        burst_code = 0;
        for (int i = 0; i < n; i++) begin
            if (fast_left > 0) fast_left--;
            else if ($urandom_range(0, 29) == 0) fast_left = $urandom_range(10, 40);
            // long runs on one channel wrap its window and push the total to its extremes
            if (burst_left == 0 && $urandom_range(0, 24) == 0) begin
                burst_left = $urandom_range(16, 24);
                burst_ch   = $urandom_range(0, NUM_CHANNELS - 1);
                burst_code = $urandom_range(0, 1) ? 4095 : $urandom_range(0, 4095);
            end
            if (burst_left > 0) begin
                it = make_item(burst_ch, burst_code, 1'b1);
                burst_left--;
            end else begin
                pick = $urandom_range(0, 7);
                code = (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(0, 4095);
                it = make_item($urandom_range(0, NUM_CHANNELS - 1), code,
                               $urandom_range(0, 6) != 0);
            end
            send_item(it, (fast_left > 0) ? 0 : $urandom_range(0, 12));
        end
    endtask

    // Result side: random pop gaps, fast stretches, one long hold on request.
    initial begin : receive_side
        int wait_cycles;
        int fast_left;
        bit hold_done;
        fast_left = 0;
        hold_done = 1'b0;
        pop <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (fast_left > 0) fast_left--;
            else if ($urandom_range(0, 29) == 0) fast_left = $urandom_range(10, 40);
            if (long_hold_req && !hold_done) begin
                wait_cycles = LONG_HOLD;
                hold_done   = 1'b1;
            end else begin
                wait_cycles = (fast_left > 0) ? 0 : $urandom_range(0, 12);
            end
            if (wait_cycles > 0) begin
                pop <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            received++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        i_rst_n    <= 1'b0;
        push       <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_MIN_SCALE;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // failed transfer on an untouched channel reports the reset window
        send_item(make_item(0, 123, 1'b0), 0);
        send_item(make_item(7, 4095, 1'b1), 0);
        send_item(make_item(7, 0, 1'b1), 1);
        // failed transfer after data leaves the history alone
        send_item(make_item(7, 4095, 1'b0), 0);
        send_item(make_item(0, 0, 1'b1), 2);
        for (int c = 0; c < NUM_CHANNELS; c++) send_item(make_item(c, 4095, 1'b1), 0);
        send_item(make_item(5, 12'hAAA, 1'b1), 0);
        send_item(make_item(2, 12'h555, 1'b1), 3);
        send_item(make_item(3, 4095, 1'b0), 0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: ;  // keep reset scaling
                1: set_scaling(0, 65535, 1'b0, 0);
                2: set_scaling(65535, 0, 1'b1, 1);
                3: set_scaling(1234, 1234, 1'b0, 2);
                4: set_scaling(65535, 65535, 1'b1, 3);
                5: set_scaling($urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 1), $urandom_range(0, 3));
                6: set_scaling(0, 0, 1'b0, 1);
                default: set_scaling($urandom_range(32768, 65535), $urandom_range(0, 32767),
                                     $urandom_range(0, 1), $urandom_range(0, 3));
            endcase
            if (phase == 3) begin
                // stall the result side and keep offering until input backs up
                long_hold_req = 1'b1;
                for (int i = 0; i < 40; i++) begin
                    send_item(make_item($urandom_range(0, NUM_CHANNELS - 1),
                                        $urandom_range(0, 4095), 1'b1), 0);
                end
                run_random(PHASE_ITEMS - 40);
            end else begin
                run_random(PHASE_ITEMS);
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        $display("covered %0d input transactions and %0d results over %0d config settings",
                 sent, received, settings_used);
        $display("including reversed and flat scaling, full windows and a long result stall");
        if (chk_pending != 0) $error("%0d expected results never arrived", chk_pending);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
